>>> hdl/ipfc_pkg.sv
`default_nettype none

package ipfc_pkg;

   localparam int SLOT_W = 3;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [15:0] frag_id;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              evicted;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_key;
      logic search;
      logic update;
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/ipfc_ctrl.sv
`default_nettype none

module ipfc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   output ipfc_pkg::cmd_type      cmd
);
   import ipfc_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MATCH  = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_MATCH;
         S_MATCH:  state_in = S_UPDATE;
         S_UPDATE: state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = (state_ff == S_DONE);
   assign cmd.load_key = (state_ff == S_IDLE) && start;
   assign cmd.search   = (state_ff == S_MATCH);
   assign cmd.update   = (state_ff == S_UPDATE);

endmodule

`default_nettype wire

>>> hdl/ipfc_datapath.sv
`default_nettype none

module ipfc_datapath #(
   parameter int ENTRIES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ipfc_pkg::cmd_type cmd,
   input  wire ipfc_pkg::req_type req_data,
   output ipfc_pkg::rsp_type      rsp_data
);
   import ipfc_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(ENTRIES - 1);

   req_type             key_ff;
   logic [31:0]         entry_addr_ff  [ENTRIES];
   logic [15:0]         entry_ident_ff [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;
   logic [RANK_W-1:0]   rank_ff [ENTRIES];
   logic [RANK_W-1:0]   rank_in [ENTRIES];
   logic [ENTRIES-1:0]  match_ff;
   logic [ENTRIES-1:0]  free_ff;
   logic [ENTRIES-1:0]  victim_ff;
   logic [ENTRIES-1:0]  match_in;
   logic [ENTRIES-1:0]  free_in;
   logic [ENTRIES-1:0]  victim_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic                hit;
   logic                has_free;
   logic [ENTRIES-1:0]  pick;
   logic [ENTRIES-1:0]  sel;
   logic [RANK_W-1:0]   limit;
   logic [SLOT_W-1:0]   slot;

   // parallel compare against every entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i]  = valid_ff[i] && (entry_addr_ff[i] == key_ff.src_ip)
                        && (entry_ident_ff[i] == key_ff.frag_id);
         free_in[i]   = !valid_ff[i];
         victim_in[i] = valid_ff[i] && (rank_ff[i] == RANK_OLDEST);
      end
   end

   // lowest set bit of the chosen vector selects the slot
   always_comb begin
      hit      = |match_ff;
      has_free = |free_ff;
      priority if (hit) begin
         pick = match_ff;
      end else if (has_free) begin
         pick = free_ff;
      end else begin
         pick = victim_ff;
      end
      sel   = pick & (~pick + ENTRIES'(1));
      limit = '0;
      slot  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            limit = limit | rank_ff[i];
            slot  = slot | SLOT_W'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (sel[i]) begin
            valid_in[i] = 1'b1;
            rank_in[i]  = '0;
         end else if (valid_ff[i] && ((!hit && has_free) || (rank_ff[i] < limit))) begin
            rank_in[i] = rank_ff[i] + RANK_W'(1);
         end
      end
      rsp_in.slot    = slot;
      rsp_in.hit     = hit;
      rsp_in.evicted = !hit && !has_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_data;
      end
      if (cmd.search) begin
         match_ff  <= match_in;
         free_ff   <= free_in;
         victim_ff <= victim_in;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i] && !hit) begin
               entry_addr_ff[i]  <= key_ff.src_ip;
               entry_ident_ff[i] <= key_ff.frag_id;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> hdl/ipv4_fragment_context_lru_table_core.sv
`default_nettype none

// Fragment context lookup with LRU replacement. Pulse start with a key while
// busy is low; busy then stays high while the key is handled, and the result
// appears on rsp_data with rsp_valid high for exactly one cycle, the last busy
// cycle, so a new key is taken only once the previous result is out (latch
// key, compare all entries in parallel, update table and ranks, present
// result). The receiver cannot stall: rsp_data must be captured in the
// rsp_valid cycle. Slot numbers are reported modulo 8 when ENTRIES exceeds 8.
module ipv4_fragment_context_lru_table_core #(
   parameter int ENTRIES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ipfc_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ipfc_pkg::rsp_type      rsp_data
);
   import ipfc_pkg::*;

   cmd_type cmd;

   ipfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ipfc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> hdl/ipfc_checker.sv
`default_nettype none

module ipfc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire ipfc_pkg::rsp_type rsp_data
);
   import ipfc_pkg::*;

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy window");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accept");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##2 rsp_valid) else $error("result latency wrong");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> !rsp_data.evicted) else $error("evict on hit");

endmodule

bind ipv4_fragment_context_lru_table_core ipfc_checker u_ipfc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
